FILE: rtl/tksit_pkg.sv
// Shared types and constants for the top-k sorted insertion table.
`timescale 1ns / 1ps

package tksit_pkg;

    localparam int MAX_DEPTH_DEF  = 16;
    localparam int SCORE_BITS_DEF = 32;
    localparam int TAG_BITS_DEF   = 16;

    localparam int FUNC_W     = 2;
    localparam int SCORE_W    = 32;
    localparam int TAG_W      = 16;
    localparam int INDEX_W    = 4;
    localparam int CFG_W      = 5;
    localparam int COUNT_W    = 5;
    localparam int POS_W      = 4;

    localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 5'd10;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_READ   = 2'd1,
        FUNC_UNMARK = 2'd2,
        FUNC_EMPTY  = 2'd3
    } t_func;

    // Per-cell control handed from the table control to each cell.
    typedef struct packed {
        logic wr_en;       // accepted insert this cycle
        logic in_range;    // cell index is below the held count
        logic prev_above;  // left neighbour stays ahead of the new entry
    } t_cell_ctl;

endpackage

FILE: rtl/tksit_cell.sv
// One table cell: holds a (score, tag) pair and shifts along the row on insert.
`timescale 1ns / 1ps

module tksit_cell
    import tksit_pkg::*;
#(
    parameter int SCORE_BITS = SCORE_BITS_DEF,
    parameter int TAG_BITS   = TAG_BITS_DEF
) (
    input  logic                         i_clk,
    input  t_cell_ctl                    i_ctl,
    input  logic signed [SCORE_BITS-1:0] i_new_score,
    input  logic        [TAG_BITS-1:0]   i_new_tag,
    input  logic signed [SCORE_BITS-1:0] i_prev_score,
    input  logic        [TAG_BITS-1:0]   i_prev_tag,
    output logic                         o_above,
    output logic signed [SCORE_BITS-1:0] o_score,
    output logic        [TAG_BITS-1:0]   o_tag
);

    logic signed [SCORE_BITS-1:0] r_score;
    logic        [TAG_BITS-1:0]   r_tag;
    logic signed [SCORE_BITS-1:0] n_score;
    logic        [TAG_BITS-1:0]   n_tag;

    // Equal scores stay ahead of the newcomer.
    assign o_above = i_ctl.in_range && (r_score >= i_new_score);

    always_comb begin
        n_score = r_score;
        n_tag   = r_tag;
        if (i_ctl.wr_en && !o_above) begin
            if (i_ctl.prev_above) begin
                n_score = i_new_score;
                n_tag   = i_new_tag;
            end else begin
                n_score = i_prev_score;
                n_tag   = i_prev_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_score <= n_score;
        r_tag   <= n_tag;
    end

    assign o_score = r_score;
    assign o_tag   = r_tag;

endmodule

FILE: rtl/top_k_sorted_insert_table_unit.sv
// Top level of the top-k sorted insertion table: control, cell row and result register.
`timescale 1ns / 1ps

// The table keeps up to max_entries (score, tag) pairs in descending score
// order in a row of MAX_DEPTH cells. Every cell compares its own score with
// the incoming one in the same cycle, so the row finds the insert position
// and shifts the lower entries one place down in that cycle: the block
// takes one transaction per cycle, unless stalled, and delivers its result
// from an output register. While that result waits on a stalled output the
// input is stalled as well, so a transaction is only taken when the result
// register is empty or being read in the same cycle. An insert that beats
// the lowest entry of a full table drops that entry. A read returns the pair
// at i_index, or zeros with o_read_valid low when the index is not below the
// count. Write max_entries only while the block is idle; 0 acts as 1 and
// values above MAX_DEPTH act as MAX_DEPTH. There is no clearing pass after
// reset.
module top_k_sorted_insert_table_unit
    import tksit_pkg::*;
#(
    parameter int MAX_DEPTH  = MAX_DEPTH_DEF,
    parameter int SCORE_BITS = SCORE_BITS_DEF,
    parameter int TAG_BITS   = TAG_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [CFG_W-1:0]          i_cfg_wdata,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [FUNC_W-1:0]         i_func,
    input  logic signed [SCORE_W-1:0] i_score,
    input  logic [TAG_W-1:0]          i_name_tag,
    input  logic [INDEX_W-1:0]        i_index,
    // output channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_accepted,
    output logic                      o_read_valid,
    output logic signed [SCORE_W-1:0] o_read_score,
    output logic [TAG_W-1:0]          o_read_tag,
    output logic [COUNT_W-1:0]        o_entry_count,
    output logic                      o_latest_valid,
    output logic [POS_W-1:0]          o_latest_pos
);

    localparam int IDX_W = $clog2(MAX_DEPTH);
    localparam int CNT_W = $clog2(MAX_DEPTH + 1);
    localparam int CAP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    // Architectural state
    logic [CFG_W-1:0]  r_max_entries;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_mark_valid, n_mark_valid;
    logic [IDX_W-1:0]  r_mark_pos, n_mark_pos;

    // Result register
    logic                      r_out_valid;
    logic                      r_accepted, n_accepted;
    logic                      r_read_valid, n_read_valid;
    logic signed [SCORE_W-1:0] r_read_score, n_read_score;
    logic [TAG_W-1:0]          r_read_tag, n_read_tag;
    logic [COUNT_W-1:0]        r_entry_count;
    logic                      r_latest_valid;
    logic [POS_W-1:0]          r_latest_pos;

    t_func                        w_func;
    logic                         w_in_fire;
    logic signed [SCORE_BITS-1:0] w_new_score;
    logic [TAG_BITS-1:0]          w_new_tag;
    logic [CAP_W-1:0]             w_cap;
    logic                         w_full;
    logic [IDX_W-1:0]             w_last_idx;
    logic                         w_ins_ok;
    logic                         w_wr_en;
    logic [IDX_W-1:0]             w_pos;
    logic                         w_rd_hit;
    logic [IDX_W-1:0]             w_rd_idx;

    logic                         w_above [MAX_DEPTH];
    logic signed [SCORE_BITS-1:0] w_score [MAX_DEPTH];
    logic [TAG_BITS-1:0]          w_tag   [MAX_DEPTH];
    t_cell_ctl                    w_ctl   [MAX_DEPTH];

    // Take a new transaction unless a finished result is held back.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_in_fire  = i_in_valid && !o_in_stall;
    assign w_func     = t_func'(i_func);

    assign w_new_score = SCORE_BITS'(signed'(i_score));
    assign w_new_tag   = TAG_BITS'(i_name_tag);

    // Clamp the capacity into 1..MAX_DEPTH.
    always_comb begin
        if (r_max_entries == '0) begin
            w_cap = CAP_W'(1);
        end else if (CAP_W'(r_max_entries) > CAP_W'(MAX_DEPTH)) begin
            w_cap = CAP_W'(MAX_DEPTH);
        end else begin
            w_cap = CAP_W'(r_max_entries);
        end
    end

    assign w_full     = CAP_W'(r_count) >= w_cap;
    assign w_last_idx = IDX_W'(r_count - 1'b1);
    // Held entries are sorted, so the newcomer beats the last one exactly
    // when that last cell does not stay ahead of it.
    assign w_ins_ok   = !w_full || !w_above[w_last_idx];
    assign w_wr_en    = w_in_fire && (w_func == FUNC_INSERT) && w_ins_ok;

    // Cell row
    for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_cell
        assign w_ctl[g].wr_en      = w_wr_en;
        assign w_ctl[g].in_range   = CNT_W'(g) < r_count;
        if (g == 0) begin : g_head
            assign w_ctl[g].prev_above = 1'b1;
            tksit_cell #(
                .SCORE_BITS (SCORE_BITS),
                .TAG_BITS   (TAG_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl[g]),
                .i_new_score  (w_new_score),
                .i_new_tag    (w_new_tag),
                .i_prev_score (w_new_score),
                .i_prev_tag   (w_new_tag),
                .o_above      (w_above[g]),
                .o_score      (w_score[g]),
                .o_tag        (w_tag[g])
            );
        end else begin : g_body
            assign w_ctl[g].prev_above = w_above[g-1];
            tksit_cell #(
                .SCORE_BITS (SCORE_BITS),
                .TAG_BITS   (TAG_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl[g]),
                .i_new_score  (w_new_score),
                .i_new_tag    (w_new_tag),
                .i_prev_score (w_score[g-1]),
                .i_prev_tag   (w_tag[g-1]),
                .o_above      (w_above[g]),
                .o_score      (w_score[g]),
                .o_tag        (w_tag[g])
            );
        end
    end

    // Insert position: the one cell where "ahead" turns off along the row.
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            if (w_ctl[i].prev_above && !w_above[i]) begin
                w_pos = w_pos | IDX_W'(i);
            end
        end
    end

    // Read port
    assign w_rd_hit = CMP_W'(i_index) < CMP_W'(r_count);
    assign w_rd_idx = IDX_W'(i_index);

    always_comb begin
        n_count      = r_count;
        n_mark_valid = r_mark_valid;
        n_mark_pos   = r_mark_pos;
        n_accepted   = 1'b0;
        n_read_valid = 1'b0;
        n_read_score = '0;
        n_read_tag   = '0;
        case (w_func)
            FUNC_INSERT: begin
                if (w_ins_ok) begin
                    n_accepted   = 1'b1;
                    n_mark_valid = 1'b1;
                    n_mark_pos   = w_pos;
                    if (CAP_W'(r_count) < w_cap) begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            FUNC_READ: begin
                if (w_rd_hit) begin
                    n_read_valid = 1'b1;
                    n_read_score = SCORE_W'(w_score[w_rd_idx]);
                    n_read_tag   = TAG_W'(w_tag[w_rd_idx]);
                end
            end
            FUNC_UNMARK: begin
                n_mark_valid = 1'b0;
            end
            FUNC_EMPTY: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= MAX_ENTRIES_RST;
            r_count       <= '0;
            r_mark_valid  <= 1'b0;
            r_mark_pos    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_entries <= i_cfg_wdata;
            end
            if (w_in_fire) begin
                r_count      <= n_count;
                r_mark_valid <= n_mark_valid;
                r_mark_pos   <= n_mark_pos;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // Result payload: load on each accepted transaction, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_accepted     <= n_accepted;
            r_read_valid   <= n_read_valid;
            r_read_score   <= n_read_score;
            r_read_tag     <= n_read_tag;
            r_entry_count  <= COUNT_W'(n_count);
            r_latest_valid <= n_mark_valid;
            r_latest_pos   <= POS_W'(n_mark_pos);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_accepted     = r_accepted;
    assign o_read_valid   = r_read_valid;
    assign o_read_score   = r_read_score;
    assign o_read_tag     = r_read_tag;
    assign o_entry_count  = r_entry_count;
    assign o_latest_valid = r_latest_valid;
    assign o_latest_pos   = r_latest_pos;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CAP_W'(r_count) <= CAP_W'(MAX_DEPTH))
        else $error("held count beyond table depth");

    a_insert_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> (r_mark_valid && o_accepted && o_out_valid))
        else $error("accepted insert did not set the latest mark");

    a_empty_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && w_func == FUNC_EMPTY) |=> (r_count == '0 && o_entry_count == '0))
        else $error("empty left entries behind");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_read_valid) |-> (o_entry_count != '0 && !o_accepted))
        else $error("valid read with no entries held");

endmodule
